FILE: src/kclt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock timer package
// Shared types, register codes and sizes for the code lock timer unit.
// ----------------------------------------------------------------------------
package kclt_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int IDX_W       = $clog2(CODE_LENGTH);
  localparam int CNT_W       = $clog2(CODE_LENGTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET_CODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DURATION  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 2'd3;

  localparam logic [7:0]  SECRET_CODE_RST    = 8'd228;
  localparam logic [11:0] DARK_THRESHOLD_RST = 12'd1000;
  localparam logic [15:0] OPEN_DURATION_RST  = 16'd10000;
  localparam logic [15:0] BLINK_INTERVAL_RST = 16'd500;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_CORRECT = 3'd2,
    EV_WRONG   = 3'd3,
    EV_CLOSED  = 3'd4
  } lock_event_t;

  typedef struct packed {
    logic [11:0] light_sample;
    logic        press_valid;
    logic [1:0]  button;
  } tick_t;

  typedef struct packed {
    logic       relay_on;
    logic       led_on;
    logic [1:0] digits_entered;
    logic [2:0] lock_event;
  } status_t;

  typedef struct packed {
    logic [7:0]  secret_code;
    logic [11:0] dark_threshold;
    logic [15:0] open_duration;
    logic [15:0] blink_interval;
  } cfg_t;

endpackage
`default_nettype wire

FILE: src/kclt_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Code lock step logic
// Lock state registers and the per-tick update; result is combinational.
// ----------------------------------------------------------------------------
module kclt_step (
  input  wire  logic            clk,
  input  wire  logic            rst,
  input  wire  logic            step,
  input  wire  kclt_pkg::tick_t tick,
  input  wire  kclt_pkg::cfg_t  cfg,
  output kclt_pkg::status_t     status
);

  logic                       door_open, door_open_next;
  logic [15:0]                open_ticks, open_ticks_next;
  logic [15:0]                blink_ticks, blink_ticks_next;
  logic                       blink_phase, blink_phase_next;
  logic [kclt_pkg::CNT_W-1:0] entry_count, entry_count_next;
  logic [1:0]                 entered_digits [kclt_pkg::CODE_LENGTH];

  logic                       dark;
  logic [15:0]                open_inc, blink_inc;
  logic [kclt_pkg::CNT_W-1:0] count_inc;
  logic                       entry_full, match, store;
  logic                       led;
  kclt_pkg::lock_event_t      event_code;
  logic [1:0]                 cand;
  logic [1:0]                 secret_digit;

  assign dark      = tick.light_sample > cfg.dark_threshold;
  assign open_inc  = (open_ticks == kclt_pkg::TICKS_MAX) ? open_ticks : open_ticks + 16'd1;
  assign blink_inc = (blink_ticks == kclt_pkg::TICKS_MAX) ? blink_ticks
                                                          : blink_ticks + 16'd1;
  assign count_inc  = entry_count + kclt_pkg::CNT_W'(1);
  assign entry_full = count_inc >= kclt_pkg::CNT_W'(kclt_pkg::CODE_LENGTH);

  // Last digit comes straight from this press.
  always_comb begin
    match        = 1'b1;
    cand         = 2'd0;
    secret_digit = 2'd0;
    for (int i = 0; i < kclt_pkg::CODE_LENGTH; i++) begin
      cand         = (i == kclt_pkg::CODE_LENGTH - 1) ? tick.button : entered_digits[i];
      secret_digit = 2'(cfg.secret_code >> (2 * i));
      if (cand != secret_digit) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    door_open_next   = door_open;
    open_ticks_next  = open_ticks;
    blink_ticks_next = blink_ticks;
    blink_phase_next = blink_phase;
    entry_count_next = entry_count;
    event_code       = kclt_pkg::EV_NONE;
    store            = 1'b0;
    led              = 1'b0;
    if (door_open) begin
      open_ticks_next = open_inc;
      if (open_inc >= cfg.open_duration) begin
        door_open_next = 1'b0;
        event_code     = kclt_pkg::EV_CLOSED;
        led            = 1'b1;
      end else begin
        blink_ticks_next = blink_inc;
        if (blink_inc >= cfg.blink_interval) begin
          blink_ticks_next = 16'd0;
          blink_phase_next = ~blink_phase;
        end
        led = blink_phase_next;
      end
    end else if (dark) begin
      led = 1'b1;
      if (tick.press_valid) begin
        store            = 1'b1;
        entry_count_next = count_inc;
        event_code       = kclt_pkg::EV_DIGIT;
        if (entry_full) begin
          if (match) begin
            door_open_next   = 1'b1;
            open_ticks_next  = 16'd0;
            blink_ticks_next = 16'd0;
            event_code       = kclt_pkg::EV_CORRECT;
          end else begin
            event_code = kclt_pkg::EV_WRONG;
          end
          entry_count_next = '0;
        end
      end
    end else begin
      entry_count_next = '0;
    end
  end

  assign status.relay_on       = door_open_next;
  assign status.led_on         = led;
  assign status.digits_entered = entry_count_next[1:0];
  assign status.lock_event     = event_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      door_open   <= 1'b0;
      open_ticks  <= 16'd0;
      blink_ticks <= 16'd0;
      blink_phase <= 1'b1;
      entry_count <= '0;
    end else if (step) begin
      door_open   <= door_open_next;
      open_ticks  <= open_ticks_next;
      blink_ticks <= blink_ticks_next;
      blink_phase <= blink_phase_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store) begin
      entered_digits[entry_count[kclt_pkg::IDX_W-1:0]] <= tick.button;
    end
  end

endmodule
`default_nettype wire

FILE: src/keypad_code_lock_timer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keypad code lock timer unit
// Code lock driven by time ticks: collects button digits in the dark,
// checks the code, holds the relay open for a set time and blinks the LED.
// ----------------------------------------------------------------------------
// One status request leaves for every tick request taken, one tick per clock
// sustained while the output side is not stalled. A tick is registered on
// entry, runs through the combinational lock update and lands in the output
// register. Config writes are always ready and take effect from the next tick
// processed.
module keypad_code_lock_timer_unit (
  input  wire  logic                              clk,
  input  wire  logic                              rst,
  input  wire  logic                              tick_valid,
  output logic                                    tick_stall,
  input  wire  kclt_pkg::tick_t                   tick,
  output logic                                    status_valid,
  input  wire  logic                              status_stall,
  output kclt_pkg::status_t                       status,
  input  wire  logic                              cfg_valid,
  output logic                                    cfg_ready,
  input  wire  logic [kclt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  logic [15:0]                       cfg_data
);

  kclt_pkg::cfg_t    cfg;
  kclt_pkg::tick_t   tick_q;
  logic              tick_q_valid;
  kclt_pkg::status_t status_next;
  logic              out_free, step;

  assign cfg_ready  = 1'b1;
  assign out_free   = ~status_valid | ~status_stall;
  assign step       = tick_q_valid & out_free;
  assign tick_stall = tick_q_valid & ~out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secret_code    <= kclt_pkg::SECRET_CODE_RST;
      cfg.dark_threshold <= kclt_pkg::DARK_THRESHOLD_RST;
      cfg.open_duration  <= kclt_pkg::OPEN_DURATION_RST;
      cfg.blink_interval <= kclt_pkg::BLINK_INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kclt_pkg::CFG_SECRET_CODE:    cfg.secret_code    <= cfg_data[7:0];
        kclt_pkg::CFG_DARK_THRESHOLD: cfg.dark_threshold <= cfg_data[11:0];
        kclt_pkg::CFG_OPEN_DURATION:  cfg.open_duration  <= cfg_data;
        kclt_pkg::CFG_BLINK_INTERVAL: cfg.blink_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (~tick_stall) begin
      tick_q_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      tick_q <= tick;
    end
  end

  kclt_step u_step (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (tick_q),
    .cfg    (cfg),
    .status (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (out_free) begin
      status_valid <= tick_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status <= status_next;
    end
  end

endmodule
`default_nettype wire
